[rtl/core/sab_pkg.sv]
// Shared types and constants for the space charge bin accumulator.
`default_nettype none
package sab_pkg;

    localparam logic [1:0] CMD_HIT    = 2'd0;
    localparam logic [1:0] CMD_EVENT  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] CFG_R_MINIMUM      = 3'd0;
    localparam logic [2:0] CFG_Z_MINIMUM      = 3'd1;
    localparam logic [2:0] CFG_R_BIN_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_Z_BIN_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_GAS_W_VALUE    = 3'd4;
    localparam logic [2:0] CFG_GEM_ION_FACTOR = 3'd5;
    localparam logic [2:0] CFG_DRIFT_FRACTION = 3'd6;
    localparam logic [2:0] CFG_MODE_BITS      = 3'd7;

    localparam logic [23:0] ION_POTENTIAL_MEV = 24'd20770;
    localparam logic [19:0] PAIR_ENERGY_MEV   = 20'd35970;

    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 24;

    typedef struct packed {
        logic        [15:0] r_minimum;
        logic signed [16:0] z_minimum;
        logic        [15:0] r_bin_width;
        logic        [15:0] z_bin_width;
        logic        [19:0] gas_w_value;
        logic        [23:0] gem_ion_factor;
        logic        [31:0] drift_fraction;
        logic        [1:0]  mode_bits;
    } t_cfg;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SQX, S_SQY, S_SUM, S_SQRT, S_DRZ, S_DIVR, S_RB,
        S_DIVZ, S_ZB, S_DIVQ, S_QSET, S_GLO, S_GHI, S_GSUM, S_RD1, S_WR1,
        S_RD2, S_WR2, S_EVT, S_EVT_CHK, S_COL, S_RDB, S_RDD, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_SQX, OP_SQY, OP_SUM, OP_SQRT, OP_DRZ,
        OP_DIV, OP_RB, OP_ZB, OP_QSET, OP_GLO, OP_GHI, OP_GSUM, OP_RD_HIT,
        OP_WR_HIT, OP_RD_B0, OP_WR_B0, OP_EVT, OP_HEAD, OP_COL, OP_RDB,
        OP_RDD, OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic outside;
        logic carry;
        logic primary;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/core/sab_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/core/sab_ctrl.sv]
// Sequencing state machine for the space charge bin accumulator.
`default_nettype none
module sab_ctrl
    import sab_pkg::*;
#(
    parameter int RADIAL_BINS = 32,
    parameter int AXIAL_BINS  = 128,
    parameter int CW          = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_cmd,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire t_dp_sts       i_sts,
    output t_dp_op             o_op,
    output logic [CW-1:0]      o_cnt
);
    localparam int DEPTH = RADIAL_BINS * AXIAL_BINS;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    t_dp_op        w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_op    = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                w_op  = OP_CLR;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_op = OP_LOAD;
                    unique case (i_cmd)
                        CMD_HIT:   n_state = S_SQX;
                        CMD_EVENT: n_state = S_EVT;
                        CMD_READ:  n_state = S_RDB;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_SQX: begin
                w_op    = OP_SQX;
                n_state = S_SQY;
            end
            S_SQY: begin
                w_op    = OP_SQY;
                n_state = S_SUM;
            end
            S_SUM: begin
                w_op    = OP_SUM;
                n_cnt   = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                w_op  = OP_SQRT;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DRZ;
                end
            end
            S_DRZ: begin
                w_op    = OP_DRZ;
                n_state = S_DIVR;
            end
            S_DIVR, S_DIVZ, S_DIVQ: begin
                w_op  = OP_DIV;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_STEPS - 1)) begin
                    n_cnt = '0;
                    if (r_state == S_DIVR) begin
                        n_state = S_RB;
                    end else if (r_state == S_DIVZ) begin
                        n_state = S_ZB;
                    end else begin
                        n_state = S_QSET;
                    end
                end
            end
            S_RB: begin
                w_op    = OP_RB;
                n_state = S_DIVZ;
            end
            S_ZB: begin
                w_op    = OP_ZB;
                n_state = S_DIVQ;
            end
            S_QSET: begin
                w_op    = OP_QSET;
                n_state = i_sts.outside ? S_FIN : S_GLO;
            end
            S_GLO: begin
                w_op    = OP_GLO;
                n_state = S_GHI;
            end
            S_GHI: begin
                w_op    = OP_GHI;
                n_state = S_GSUM;
            end
            S_GSUM: begin
                w_op    = OP_GSUM;
                n_state = S_RD1;
            end
            S_RD1: begin
                w_op    = OP_RD_HIT;
                n_state = S_WR1;
            end
            S_WR1: begin
                w_op    = OP_WR_HIT;
                n_state = i_sts.primary ? S_FIN : S_RD2;
            end
            S_RD2: begin
                w_op    = OP_RD_B0;
                n_state = S_WR2;
            end
            S_WR2: begin
                w_op    = OP_WR_B0;
                n_state = S_FIN;
            end
            S_EVT: begin
                w_op    = OP_EVT;
                n_state = S_EVT_CHK;
            end
            S_EVT_CHK: begin
                if (i_sts.carry) begin
                    w_op    = OP_HEAD;
                    n_cnt   = '0;
                    n_state = S_COL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_COL: begin
                w_op  = OP_COL;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(RADIAL_BINS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end
            end
            S_RDB: begin
                w_op    = OP_RDB;
                n_state = S_RDD;
            end
            S_RDD: begin
                w_op    = OP_RDD;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    w_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_op == OP_OUT) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_op        = w_op;
    assign o_cnt       = r_cnt;
endmodule
`default_nettype wire

[rtl/core/sab_dp.sv]
// Datapath: square root, shared divider, charge arithmetic and map access.
`default_nettype none
module sab_dp
    import sab_pkg::*;
#(
    parameter int RADIAL_BINS = 32,
    parameter int AXIAL_BINS  = 128,
    parameter int CW          = 13
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_dp_op             i_op,
    input  wire logic [CW-1:0]      i_cnt,
    output t_dp_sts                 o_sts,
    input  wire logic signed [16:0] i_pos_x,
    input  wire logic signed [16:0] i_pos_y,
    input  wire logic signed [16:0] i_pos_z,
    input  wire logic [23:0]        i_energy_loss,
    input  wire logic [4:0]         i_read_radius_bin,
    input  wire logic [6:0]         i_read_axial_bin,
    output logic                    o_status,
    output logic [31:0]             o_bin_charge,
    output logic [31:0]             o_outside_hits,
    output logic                    o_drifted
);
    localparam int DEPTH = RADIAL_BINS * AXIAL_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int ZW    = $clog2(AXIAL_BINS);

    function automatic logic [ZW-1:0] f_phys(input logic [ZW-1:0] head,
                                             input logic [ZW-1:0] z);
        logic [ZW:0] s;
        s = {1'b0, head} + {1'b0, z};
        if (s >= (ZW+1)'(AXIAL_BINS)) begin
            s = s - (ZW+1)'(AXIAL_BINS);
        end
        return s[ZW-1:0];
    endfunction

    logic signed [16:0] r_x, r_y, r_z;
    logic [23:0]        r_e;
    logic [4:0]         r_rr;
    logic [6:0]         r_zz;
    logic [32:0]        r_sqx, r_sqy;
    logic [33:0]        r_sq;
    logic [18:0]        r_rem;
    logic [16:0]        r_root;
    logic [23:0]        r_dz;
    logic [23:0]        r_dvd;
    logic [19:0]        r_dvs;
    logic [19:0]        r_remd;
    logic [23:0]        r_rb, r_zb, r_q;
    logic [35:0]        r_glo, r_ghi;
    logic [39:0]        r_gas;
    logic [AW-1:0]      r_row, r_addr_hit, r_addr_b0;
    logic [ZW-1:0]      r_head;
    logic [31:0]        r_phase, r_count;
    logic               r_carry, r_rd_ok;
    logic               r_status, r_drifted;
    logic [31:0]        r_charge;
    logic               r_out_status, r_out_drifted;
    logic [31:0]        r_out_charge, r_out_count;

    logic signed [33:0] w_sqx, w_sqy;
    logic [19:0]        w_trem, w_trial;
    logic [20:0]        w_tdiv;
    logic signed [17:0] w_dr, w_dz;
    logic               w_outside, w_ebig;
    logic [19:0]        w_rw, w_zw, w_ww;
    logic [32:0]        w_phase;
    logic [32:0]        w_sum_q;
    logic [40:0]        w_sum_g;
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr, w_rd_addr;
    logic [31:0]        w_wdata, w_rdata;

    assign w_sqx   = r_x * r_x;
    assign w_sqy   = r_y * r_y;
    assign w_trem  = {r_rem[17:0], r_sq[33:32]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_tdiv  = {r_remd, r_dvd[23]};
    assign w_dr    = $signed({1'b0, r_root}) - $signed({2'b00, i_cfg.r_minimum});
    assign w_dz    = 18'(r_z) - 18'(i_cfg.z_minimum);
    assign w_outside = (r_rb >= 24'(RADIAL_BINS)) || (r_zb >= 24'(AXIAL_BINS));
    assign w_ebig  = (r_e > ION_POTENTIAL_MEV);
    assign w_rw    = (i_cfg.r_bin_width == '0) ? 20'd1 : {4'd0, i_cfg.r_bin_width};
    assign w_zw    = (i_cfg.z_bin_width == '0) ? 20'd1 : {4'd0, i_cfg.z_bin_width};
    assign w_ww    = (i_cfg.gas_w_value == '0) ? 20'd1 : i_cfg.gas_w_value;
    assign w_phase = {1'b0, r_phase} + {1'b0, i_cfg.drift_fraction};
    assign w_sum_q = {1'b0, w_rdata} + {9'd0, r_q};
    assign w_sum_g = {9'd0, w_rdata} + {1'b0, r_gas};
    assign w_rd_addr = AW'(int'(r_rr) * AXIAL_BINS) + AW'(f_phys(r_head, ZW'(r_zz)));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr_hit;
        w_wdata = '0;
        w_raddr = r_addr_hit;
        case (i_op)
            OP_CLR: begin
                w_we    = 1'b1;
                w_waddr = i_cnt[AW-1:0];
            end
            OP_COL: begin
                w_we    = 1'b1;
                w_waddr = AW'(int'(i_cnt) * AXIAL_BINS) + AW'(r_head);
            end
            OP_WR_HIT: begin
                w_we    = 1'b1;
                w_wdata = w_sum_q[32] ? 32'hFFFF_FFFF : w_sum_q[31:0];
            end
            OP_RD_B0: w_raddr = r_addr_b0;
            OP_WR_B0: begin
                w_we    = 1'b1;
                w_waddr = r_addr_b0;
                w_wdata = (w_sum_g[40:32] != '0) ? 32'hFFFF_FFFF : w_sum_g[31:0];
            end
            OP_RDB: w_raddr = w_rd_addr;
            default: ;
        endcase
    end

    sab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_phase <= '0;
            r_count <= '0;
        end else begin
            case (i_op)
                OP_QSET: begin
                    if (w_outside && r_count != 32'hFFFF_FFFF) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_EVT:  r_phase <= w_phase[31:0];
                OP_HEAD: r_head  <= (r_head == '0) ? ZW'(AXIAL_BINS - 1) : r_head - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_x       <= i_pos_x;
                r_y       <= i_pos_y;
                r_z       <= i_pos_z;
                r_e       <= i_energy_loss;
                r_rr      <= i_read_radius_bin;
                r_zz      <= i_read_axial_bin;
                r_status  <= 1'b0;
                r_drifted <= 1'b0;
                r_charge  <= '0;
                r_carry   <= 1'b0;
            end
            OP_SQX: r_sqx <= w_sqx[32:0];
            OP_SQY: r_sqy <= w_sqy[32:0];
            OP_SUM: begin
                r_sq   <= {1'b0, r_sqx} + {1'b0, r_sqy};
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_sq <= {r_sq[31:0], 2'b00};
                if (w_trem >= w_trial) begin
                    r_rem  <= 19'(w_trem - w_trial);
                    r_root <= {r_root[15:0], 1'b1};
                end else begin
                    r_rem  <= w_trem[18:0];
                    r_root <= {r_root[15:0], 1'b0};
                end
            end
            OP_DRZ: begin
                r_dvd  <= 24'(w_dr[17] ? -w_dr : w_dr);
                r_dz   <= 24'(w_dz[17] ? -w_dz : w_dz);
                r_dvs  <= w_rw;
                r_remd <= '0;
            end
            OP_DIV: begin
                if (w_tdiv >= {1'b0, r_dvs}) begin
                    r_remd <= 20'(w_tdiv - {1'b0, r_dvs});
                    r_dvd  <= {r_dvd[22:0], 1'b1};
                end else begin
                    r_remd <= w_tdiv[19:0];
                    r_dvd  <= {r_dvd[22:0], 1'b0};
                end
            end
            OP_RB: begin
                r_rb   <= r_dvd;
                r_dvd  <= r_dz;
                r_dvs  <= w_zw;
                r_remd <= '0;
            end
            OP_ZB: begin
                r_zb   <= r_dvd;
                r_remd <= '0;
                if (i_cfg.mode_bits[0]) begin
                    r_dvd <= w_ebig ? r_e - ION_POTENTIAL_MEV : '0;
                    r_dvs <= PAIR_ENERGY_MEV;
                end else begin
                    r_dvd <= r_e;
                    r_dvs <= w_ww;
                end
            end
            OP_QSET: begin
                if (i_cfg.mode_bits[0]) begin
                    r_q <= w_ebig ? r_dvd + 1'b1 : '0;
                end else begin
                    r_q <= r_dvd;
                end
                r_status <= w_outside;
                r_row    <= AW'(int'(r_rb) * AXIAL_BINS);
            end
            OP_GLO: r_glo <= r_q * i_cfg.gem_ion_factor[11:0];
            OP_GHI: r_ghi <= r_q * i_cfg.gem_ion_factor[23:12];
            OP_GSUM: begin
                r_gas      <= 40'(({12'd0, r_glo} + {r_ghi, 12'd0}) >> 8);
                r_addr_hit <= r_row + AW'(f_phys(r_head, ZW'(r_zb)));
                r_addr_b0  <= r_row + AW'(r_head);
            end
            OP_EVT: begin
                r_carry   <= w_phase[32];
                r_drifted <= w_phase[32];
            end
            OP_RDB: r_rd_ok <= (int'(r_rr) < RADIAL_BINS) && (int'(r_zz) < AXIAL_BINS);
            OP_RDD: r_charge <= r_rd_ok ? w_rdata : '0;
            OP_OUT: begin
                r_out_status  <= r_status;
                r_out_drifted <= r_drifted;
                r_out_charge  <= r_charge;
                r_out_count   <= r_count;
            end
            default: ;
        endcase
    end

    assign o_sts.outside = w_outside;
    assign o_sts.carry   = r_carry;
    assign o_sts.primary = i_cfg.mode_bits[1];

    assign o_status       = r_out_status;
    assign o_bin_charge   = r_out_charge;
    assign o_outside_hits = r_out_count;
    assign o_drifted      = r_out_drifted;
endmodule
`default_nettype wire

[rtl/core/space_charge_bin_accumulator_unit.sv]
// Top level: configuration registers, controller and datapath.
// Hit: square root, three divisions and a map update (no second update at the head column
// when primary-only, no update at all when outside the volume). End of event: when the map
// drifts, one column is cleared. Read: one bin; unused command: result only. One item at a time;
// the divider runs 24 steps per quotient. After reset the map is cleared before
// the first item is taken; configuration writes are taken at any time.
`default_nettype none
module space_charge_bin_accumulator_unit
    import sab_pkg::*;
#(
    parameter int RADIAL_BINS = 32,
    parameter int AXIAL_BINS  = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [16:0] i_pos_x,
    input  wire logic signed [16:0] i_pos_y,
    input  wire logic signed [16:0] i_pos_z,
    input  wire logic [23:0]        i_energy_loss,
    input  wire logic [4:0]         i_read_radius_bin,
    input  wire logic [6:0]         i_read_axial_bin,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_status,
    output logic [31:0]             o_bin_charge,
    output logic [31:0]             o_outside_hits,
    output logic                    o_drifted,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    localparam int DEPTH = RADIAL_BINS * AXIAL_BINS;
    localparam int CW    = ($clog2(DEPTH + 1) > 5) ? $clog2(DEPTH + 1) : 5;

    t_cfg          r_cfg;
    t_dp_op        w_op;
    t_dp_sts       w_sts;
    logic [CW-1:0] w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.r_minimum      <= 16'd3968;
            r_cfg.z_minimum      <= -17'sd10112;
            r_cfg.r_bin_width    <= 16'd256;
            r_cfg.z_bin_width    <= 16'd509;
            r_cfg.gas_w_value    <= 20'd35970;
            r_cfg.gem_ion_factor <= 24'd1280;
            r_cfg.drift_fraction <= 32'd0;
            r_cfg.mode_bits      <= 2'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_R_MINIMUM:      r_cfg.r_minimum      <= i_cfg_data[15:0];
                CFG_Z_MINIMUM:      r_cfg.z_minimum      <= i_cfg_data[16:0];
                CFG_R_BIN_WIDTH:    r_cfg.r_bin_width    <= i_cfg_data[15:0];
                CFG_Z_BIN_WIDTH:    r_cfg.z_bin_width    <= i_cfg_data[15:0];
                CFG_GAS_W_VALUE:    r_cfg.gas_w_value    <= i_cfg_data[19:0];
                CFG_GEM_ION_FACTOR: r_cfg.gem_ion_factor <= i_cfg_data[23:0];
                CFG_DRIFT_FRACTION: r_cfg.drift_fraction <= i_cfg_data;
                CFG_MODE_BITS:      r_cfg.mode_bits      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    sab_ctrl #(
        .RADIAL_BINS (RADIAL_BINS),
        .AXIAL_BINS  (AXIAL_BINS),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_op        (w_op),
        .o_cnt       (w_cnt)
    );

    sab_dp #(
        .RADIAL_BINS (RADIAL_BINS),
        .AXIAL_BINS  (AXIAL_BINS),
        .CW          (CW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_op              (w_op),
        .i_cnt             (w_cnt),
        .o_sts             (w_sts),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_pos_z           (i_pos_z),
        .i_energy_loss     (i_energy_loss),
        .i_read_radius_bin (i_read_radius_bin),
        .i_read_axial_bin  (i_read_axial_bin),
        .o_status          (o_status),
        .o_bin_charge      (o_bin_charge),
        .o_outside_hits    (o_outside_hits),
        .o_drifted         (o_drifted)
    );
endmodule
`default_nettype wire

[rtl/core/sab_checker.sv]
// Port-level checks for the space charge bin accumulator, bound to the top level.
`default_nettype none
module sab_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [1:0]         i_cmd,
    input wire logic signed [16:0] i_pos_x,
    input wire logic signed [16:0] i_pos_y,
    input wire logic signed [16:0] i_pos_z,
    input wire logic [23:0]        i_energy_loss,
    input wire logic [4:0]         i_read_radius_bin,
    input wire logic [6:0]         i_read_axial_bin,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_status,
    input wire logic [31:0]        o_bin_charge,
    input wire logic [31:0]        o_outside_hits,
    input wire logic               o_drifted,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic [2:0]         i_cfg_index,
    input wire logic [31:0]        i_cfg_data
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat taken while busy");

    a_outside_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_bin_charge == 32'd0 && !o_drifted)
        else $error("outside hit carries charge or drift");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bin_charge)
            && $stable(o_outside_hits))
        else $error("stalled result beat changed");
endmodule

bind space_charge_bin_accumulator_unit sab_checker u_sab_checker (.*);
`default_nettype wire
